@@ hdl/mcrbf_pkg.sv @@
// Package for the multi-channel receive byte FIFO.
// Holds default sizes, request and status codes and the empty-read byte.
// No dependencies.
package mcrbf_pkg;

    // Default sizes
    localparam int DEPTH_DEFAULT    = 64;
    localparam int CHANNELS_DEFAULT = 3;

    // Fixed field widths
    localparam int REQ_W   = 1;
    localparam int CHAN_W  = 2;
    localparam int BYTE_W  = 8;
    localparam int FILL_W  = 7;
    localparam int STAT_W  = 2;

    // Request kinds
    localparam logic [REQ_W-1:0] REQ_PUSH = 1'b0;
    localparam logic [REQ_W-1:0] REQ_POP  = 1'b1;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 2'd0,
        ST_DROPPED = 2'd1,
        ST_EMPTY   = 2'd2
    } status_t;

    // Byte returned on push and on pop from an empty ring
    localparam logic [BYTE_W-1:0] EMPTY_BYTE = 8'hFF;

endpackage

@@ hdl/multi_channel_rx_byte_fifo_top.sv @@
// Top level of the multi-channel receive byte FIFO.
// One ring of DEPTH bytes per channel in a shared memory, with per-channel pointers.
// Depends on mcrbf_pkg.
//
//  channel | group            | tdata (low bit up)            | tuser (low bit up)
//  --------+------------------+-------------------------------+-------------------------
//  request | s_tvalid/tready  | rx_byte[7:0]                  | req_type[0], channel[2:1]
//  result  | m_tvalid/tready  | read_byte[7:0], fill_count    | status[1:0]
//          |                  | [14:8], zero pad [15]         |
//
// Each result is registered and appears in the cycle after its request is taken; a
// request is taken every cycle while the result register is empty or being drained.
// The memory read port feeds the result register. Reset clears all pointers and fill
// counts; memory contents stay undefined. A stalled result holds the request side.
module multi_channel_rx_byte_fifo_top
    import mcrbf_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEFAULT,
    parameter int CHANNELS = CHANNELS_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic [2:0]  s_tuser,   // req_type[0], channel[2:1]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // read_byte[7:0], fill_count[14:8], zero[15]
    output logic [1:0]  m_tuser    // status[1:0]
);

    localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int ADDR_W = (CHANNELS * DEPTH > 1) ? $clog2(CHANNELS * DEPTH) : 1;
    localparam int CMP_W  = 4;

    // Per-channel ring state
    logic [PTR_W-1:0]  wr_ptr_reg [CHANNELS];
    logic [PTR_W-1:0]  rd_ptr_reg [CHANNELS];
    logic [CNT_W-1:0]  count_reg  [CHANNELS];

    // Byte memory
    logic [BYTE_W-1:0] mem [CHANNELS * DEPTH];

    // Result register
    logic              out_valid_reg;
    logic              read_ok_reg;
    logic [BYTE_W-1:0] rd_data_reg;
    logic [FILL_W-1:0] fill_reg;
    status_t           status_reg;

    // Request fields
    logic [REQ_W-1:0]  req_type;
    logic [CHAN_W-1:0] chan;
    logic [BYTE_W-1:0] rx_byte;

    // Selected channel view and step decisions
    logic              accept;
    logic              chan_ok;
    logic [PTR_W-1:0]  sel_wr_ptr;
    logic [PTR_W-1:0]  sel_rd_ptr;
    logic [CNT_W-1:0]  sel_count;
    logic              sel_full;
    logic              sel_empty;
    logic              push_ok;
    logic              pop_ok;
    logic [ADDR_W-1:0] ring_base;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr;
    logic [CNT_W-1:0]  count_next;
    logic [FILL_W-1:0] fill_next;
    status_t           status_next;

    assign req_type = s_tuser[0];
    assign chan     = s_tuser[2:1];
    assign rx_byte  = s_tdata;

    // Take a request when the result register is free or drains this cycle
    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    // Select the addressed channel's pointers and count
    always_comb
    begin
        sel_wr_ptr = '0;
        sel_rd_ptr = '0;
        sel_count  = '0;
        for (int c = 0; c < CHANNELS; c++)
        begin
            if (CMP_W'(chan) == CMP_W'(c))
            begin
                sel_wr_ptr = wr_ptr_reg[c];
                sel_rd_ptr = rd_ptr_reg[c];
                sel_count  = count_reg[c];
            end
        end
    end

    assign chan_ok   = CMP_W'(chan) < CMP_W'(CHANNELS);
    assign sel_full  = sel_count == CNT_W'(DEPTH);
    assign sel_empty = sel_count == '0;
    assign push_ok   = chan_ok && (req_type == REQ_PUSH) && !sel_full;
    assign pop_ok    = chan_ok && (req_type == REQ_POP) && !sel_empty;

    assign ring_base = ADDR_W'(chan) * ADDR_W'(DEPTH);
    assign wr_addr   = ring_base + ADDR_W'(sel_wr_ptr);
    assign rd_addr   = ring_base + ADDR_W'(sel_rd_ptr);

    // Fill count and status after the step
    always_comb
    begin
        count_next = sel_count;
        if (push_ok)
        begin
            count_next = sel_count + CNT_W'(1);
        end
        else if (pop_ok)
        begin
            count_next = sel_count - CNT_W'(1);
        end
        fill_next = chan_ok ? FILL_W'(count_next) : '0;

        if (req_type == REQ_PUSH)
        begin
            status_next = push_ok ? ST_OK : ST_DROPPED;
        end
        else
        begin
            status_next = pop_ok ? ST_OK : ST_EMPTY;
        end
    end

    // Advance pointers and counts of the addressed channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                wr_ptr_reg[c] <= '0;
                rd_ptr_reg[c] <= '0;
                count_reg[c]  <= '0;
            end
        end
        else if (accept)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                if (CMP_W'(chan) == CMP_W'(c))
                begin
                    if (push_ok)
                    begin
                        wr_ptr_reg[c] <= (sel_wr_ptr == PTR_W'(DEPTH - 1)) ? '0
                                         : sel_wr_ptr + PTR_W'(1);
                        count_reg[c]  <= count_next;
                    end
                    else if (pop_ok)
                    begin
                        rd_ptr_reg[c] <= (sel_rd_ptr == PTR_W'(DEPTH - 1)) ? '0
                                         : sel_rd_ptr + PTR_W'(1);
                        count_reg[c]  <= count_next;
                    end
                end
            end
        end
    end

    // Write pushed bytes, read popped bytes into the result register
    always_ff @(posedge clk)
    begin
        if (accept && push_ok)
        begin
            mem[wr_addr] <= rx_byte;
        end
        if (accept && pop_ok)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // Result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            read_ok_reg <= pop_ok;
            fill_reg    <= fill_next;
            status_reg  <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, fill_reg, (read_ok_reg ? rd_data_reg : EMPTY_BYTE)};
    assign m_tuser  = status_reg;

endmodule
